// File: src/assert_macros.svh
// Assertion macros shared by the SHA-1 hasher RTL.
// Each macro builds one clocked, reset-qualified concurrent assertion.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SHA1_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha1 assertion failed");

// Next-cycle implication.
`define SHA1_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha1 assertion failed");

`endif

// File: src/sha1_pkg.sv
// Package for the SHA-1 hasher: field widths, round constants and initial hash values.
// Used by the channel interfaces and the top level; no dependencies.
`timescale 1ns / 1ps

package sha1_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned INDEX_W = 3;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [INDEX_W-1:0] index_t;

  localparam word_t K_ROUND0 = 32'h5A82_7999;
  localparam word_t K_ROUND1 = 32'h6ED9_EBA1;
  localparam word_t K_ROUND2 = 32'h8F1B_BCDC;
  localparam word_t K_ROUND3 = 32'hCA62_C1D6;

  localparam word_t H_INIT0 = 32'h6745_2301;
  localparam word_t H_INIT1 = 32'hEFCD_AB89;
  localparam word_t H_INIT2 = 32'h98BA_DCFE;
  localparam word_t H_INIT3 = 32'h1032_5476;
  localparam word_t H_INIT4 = 32'hC3D2_E1F0;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam count_t     MAX_BYTES = 3'd4;
  localparam index_t     LAST_INDEX = 3'd4;

endpackage

// File: src/sha1_in_if.sv
// Message request channel of the SHA-1 hasher: valid/ready plus one data word.
// Depends on sha1_pkg.
`timescale 1ns / 1ps

interface sha1_in_if;
  logic               valid;
  logic               ready;
  sha1_pkg::word_t    data_word;
  sha1_pkg::count_t   byte_count;
  logic               last;

  modport source (output valid, output data_word, output byte_count, output last,
                  input ready);
  modport sink (input valid, input data_word, input byte_count, input last,
                output ready);
endinterface

// File: src/sha1_out_if.sv
// Digest channel of the SHA-1 hasher: valid/ready plus one digest word.
// Depends on sha1_pkg.
`timescale 1ns / 1ps

interface sha1_out_if;
  logic               valid;
  logic               ready;
  sha1_pkg::word_t    digest_word;
  sha1_pkg::index_t   word_index;
  logic               last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

// File: src/sha1_hash_stream.sv
// Channel    | Dir | Payload                              | Handshake
// in_ch      | in  | data_word, byte_count, last          | valid / ready
// out_ch     | out | digest_word, word_index, last_word    | valid / ready
//
// A request that does not complete a block is accepted, then its bytes are inserted.
// Completing a 64-byte block adds 80 rounds through one round unit, then one add.
// A last request adds padding (one or two blocks) and five digest words, one per cycle.
// Reset (rst_n, synchronous, active low) loads the initial hash values; no clearing pass.
// in_ch.ready is low while a request is being processed or the digest is being sent;
// a stalled out_ch holds the current digest word until it is taken.
//
// Depends on sha1_pkg, sha1_in_if, sha1_out_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sha1_hash_stream (
  input  logic        clk,
  input  logic        rst_n,
  sha1_in_if.sink     in_ch,
  sha1_out_if.source  out_ch
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_INSERT = 3'd1;
  localparam logic [2:0] ST_PAD    = 3'd2;
  localparam logic [2:0] ST_PAD2   = 3'd3;
  localparam logic [2:0] ST_ROUND  = 3'd4;
  localparam logic [2:0] ST_ADD    = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  localparam logic [1:0] PS_DATA  = 2'd0;
  localparam logic [1:0] PS_EXTRA = 2'd1;
  localparam logic [1:0] PS_FINAL = 2'd2;

  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [5:0] LAST_LEN_FILL = 6'd55;

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        pad_stage_r, pad_stage_nxt;
  logic [6:0]        round_r, round_nxt;
  logic [5:0]        fill_r, fill_nxt;
  logic [60:0]       msg_r, msg_nxt;
  sha1_pkg::word_t   word_r, word_nxt;
  sha1_pkg::count_t  cnt_r, cnt_nxt;
  logic              last_r, last_nxt;
  logic              out_valid_r, out_valid_nxt;
  sha1_pkg::index_t  out_idx_r, out_idx_nxt;
  sha1_pkg::word_t   chain_r [5];
  sha1_pkg::word_t   chain_nxt [5];
  sha1_pkg::word_t   blk_r [16];
  sha1_pkg::word_t   blk_nxt [16];
  sha1_pkg::word_t   a_r, b_r, c_r, d_r, e_r;
  sha1_pkg::word_t   a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;

  logic              in_acc;
  logic              out_acc;
  sha1_pkg::count_t  cnt_in;
  logic [6:0]        room;
  sha1_pkg::count_t  n_fit;
  logic [6:0]        fill_sum;
  logic [63:0]       bit_len;
  sha1_pkg::word_t   f_val;
  sha1_pkg::word_t   k_val;
  sha1_pkg::word_t   t_val;
  logic              start_rounds;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign cnt_in  = (in_ch.byte_count > sha1_pkg::MAX_BYTES) ? sha1_pkg::MAX_BYTES
                                                            : in_ch.byte_count;
  assign bit_len = {msg_r, 3'b000};

  assign room     = 7'd64 - {1'b0, fill_r};
  assign n_fit    = ({4'd0, cnt_r} <= room) ? cnt_r : room[2:0];
  assign fill_sum = {1'b0, fill_r} + {4'd0, n_fit};

  // Round function and constant of the current round.
  always_comb begin
    if (round_r < 7'd20) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
      k_val = sha1_pkg::K_ROUND0;
    end else if (round_r < 7'd40) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = sha1_pkg::K_ROUND1;
    end else if (round_r < 7'd60) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_val = sha1_pkg::K_ROUND2;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = sha1_pkg::K_ROUND3;
    end
  end

  assign t_val = {a_r[26:0], a_r[31:27]} + f_val + e_r + k_val + blk_r[0];

  always_comb begin
    logic [5:0] pos;
    state_nxt     = state_r;
    pad_stage_nxt = pad_stage_r;
    round_nxt     = round_r;
    fill_nxt      = fill_r;
    msg_nxt       = msg_r;
    word_nxt      = word_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    chain_nxt     = chain_r;
    blk_nxt       = blk_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    e_nxt         = e_r;
    start_rounds  = 1'b0;
    pos           = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          word_nxt  = in_ch.data_word;
          cnt_nxt   = cnt_in;
          last_nxt  = in_ch.last;
          msg_nxt   = msg_r + {58'd0, cnt_in};
          state_nxt = ST_INSERT;
        end
      end

      ST_INSERT: begin
        // Write as many bytes as fit in the current block; the rest wait for the next.
        for (int k = 0; k < 4; k++) begin
          if (3'(k) < n_fit) begin
            pos = fill_r + 6'(k);
            blk_nxt[pos[5:2]][{~pos[1:0], 3'b000} +: 8] = word_r[31 - 8*k -: 8];
          end
        end
        word_nxt = word_r << {n_fit, 3'b000};
        cnt_nxt  = cnt_r - n_fit;
        fill_nxt = fill_sum[5:0];
        if (fill_sum[6]) begin
          start_rounds = 1'b1;
        end else if (last_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_PAD: begin
        for (int p = 0; p < 64; p++) begin
          if (6'(p) == fill_r) begin
            blk_nxt[p / 4][(3 - p % 4) * 8 +: 8] = sha1_pkg::PAD_BYTE;
          end else if (6'(p) > fill_r) begin
            blk_nxt[p / 4][(3 - p % 4) * 8 +: 8] = 8'h00;
          end
        end
        // The length goes in this block only if the pad byte leaves room for it.
        if (fill_r <= LAST_LEN_FILL) begin
          blk_nxt[14]   = bit_len[63:32];
          blk_nxt[15]   = bit_len[31:0];
          pad_stage_nxt = PS_FINAL;
        end else begin
          pad_stage_nxt = PS_EXTRA;
        end
        fill_nxt     = '0;
        start_rounds = 1'b1;
      end

      ST_PAD2: begin
        for (int w = 0; w < 14; w++) begin
          blk_nxt[w] = '0;
        end
        blk_nxt[14]   = bit_len[63:32];
        blk_nxt[15]   = bit_len[31:0];
        pad_stage_nxt = PS_FINAL;
        start_rounds  = 1'b1;
      end

      ST_ROUND: begin
        e_nxt = d_r;
        d_nxt = c_r;
        c_nxt = {b_r[1:0], b_r[31:2]};
        b_nxt = a_r;
        a_nxt = t_val;
        // The block doubles as the message schedule window.
        for (int w = 0; w < 15; w++) begin
          blk_nxt[w] = blk_r[w + 1];
        end
        blk_nxt[15] = {blk_r[13][30:0] ^ blk_r[8][30:0] ^ blk_r[2][30:0] ^ blk_r[0][30:0],
                       blk_r[13][31] ^ blk_r[8][31] ^ blk_r[2][31] ^ blk_r[0][31]};
        round_nxt = round_r + 7'd1;
        if (round_r == LAST_ROUND) begin
          state_nxt = ST_ADD;
        end
      end

      ST_ADD: begin
        chain_nxt[0] = chain_r[0] + a_r;
        chain_nxt[1] = chain_r[1] + b_r;
        chain_nxt[2] = chain_r[2] + c_r;
        chain_nxt[3] = chain_r[3] + d_r;
        chain_nxt[4] = chain_r[4] + e_r;
        if (pad_stage_r == PS_FINAL) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = '0;
          state_nxt     = ST_OUT;
        end else if (pad_stage_r == PS_EXTRA) begin
          state_nxt = ST_PAD2;
        end else if (cnt_r != '0) begin
          state_nxt = ST_INSERT;
        end else if (last_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_OUT: begin
        if (out_acc) begin
          if (out_idx_r == sha1_pkg::LAST_INDEX) begin
            out_valid_nxt = 1'b0;
            chain_nxt[0]  = sha1_pkg::H_INIT0;
            chain_nxt[1]  = sha1_pkg::H_INIT1;
            chain_nxt[2]  = sha1_pkg::H_INIT2;
            chain_nxt[3]  = sha1_pkg::H_INIT3;
            chain_nxt[4]  = sha1_pkg::H_INIT4;
            fill_nxt      = '0;
            msg_nxt       = '0;
            pad_stage_nxt = PS_DATA;
            last_nxt      = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            out_idx_nxt = out_idx_r + 3'd1;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (start_rounds) begin
      a_nxt     = chain_r[0];
      b_nxt     = chain_r[1];
      c_nxt     = chain_r[2];
      d_nxt     = chain_r[3];
      e_nxt     = chain_r[4];
      round_nxt = '0;
      state_nxt = ST_ROUND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pad_stage_r <= PS_DATA;
      round_r     <= '0;
      fill_r      <= '0;
      msg_r       <= '0;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_idx_r   <= '0;
      chain_r[0]  <= sha1_pkg::H_INIT0;
      chain_r[1]  <= sha1_pkg::H_INIT1;
      chain_r[2]  <= sha1_pkg::H_INIT2;
      chain_r[3]  <= sha1_pkg::H_INIT3;
      chain_r[4]  <= sha1_pkg::H_INIT4;
    end else begin
      state_r     <= state_nxt;
      pad_stage_r <= pad_stage_nxt;
      round_r     <= round_nxt;
      fill_r      <= fill_nxt;
      msg_r       <= msg_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      out_idx_r   <= out_idx_nxt;
      chain_r     <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    blk_r  <= blk_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    c_r    <= c_nxt;
    d_r    <= d_nxt;
    e_r    <= e_nxt;
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.digest_word = chain_r[out_idx_r];
  assign out_ch.word_index  = out_idx_r;
  assign out_ch.last_word   = (out_idx_r == sha1_pkg::LAST_INDEX);

  `SHA1_ASSERT_NOW(a_no_req_while_digest, clk, rst_n, out_ch.valid, !in_ch.ready)
  `SHA1_ASSERT_NEXT(a_restart_after_digest, clk, rst_n, out_acc && out_ch.last_word,
    (chain_r[0] == sha1_pkg::H_INIT0) && (msg_r == '0) && (fill_r == '0) && in_ch.ready)
  `SHA1_ASSERT_NOW(a_final_has_no_bytes, clk, rst_n, pad_stage_r != PS_DATA, cnt_r == '0)
  `SHA1_ASSERT_NOW(a_round_in_range, clk, rst_n, state_r == ST_ROUND, round_r <= LAST_ROUND)

endmodule
